### design/lmss_pkg.sv
// shared types, codes and defaults of the led matrix scroll scanner
package lmss_pkg;

  localparam int ROWS_DEF        = 8;
  localparam int COLUMNS_DEF     = 8;
  localparam int STORE_DEPTH_DEF = 256;

  localparam int DATA_W  = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_STATIC = 2'd2;
  localparam logic [1:0] OP_SCROLL = 2'd3;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STATIC = 2'd1;
  localparam logic [1:0] MODE_SCROLL = 2'd2;

  localparam logic [1:0] REG_LEVEL  = 2'd0;
  localparam logic [1:0] REG_DWELL  = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;
  localparam logic [1:0] REG_LENGTH = 2'd3;

  localparam logic        LEVEL_RESET  = 1'b1;
  localparam logic [15:0] DWELL_RESET  = 16'd2500;
  localparam logic [12:0] FRAMES_RESET = 13'd10;
  localparam logic [7:0]  LENGTH_RESET = 8'd8;

  localparam logic [7:0] SCROLL_MARGIN = 8'd7;

  typedef struct packed {
    logic        level;
    logic [15:0] dwell;
    logic [12:0] frames;
    logic [7:0]  length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] column_drive;
    logic       row_en;
    logic       busy;
    logic       done;
  } result_t;

endpackage

### design/lmss_ram.sv
// generic single-write, single-read ram with registered read data
module lmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lmss_regs.sv
// apb configuration registers of the led matrix scroll scanner
module lmss_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmss_pkg::PADDR_W-1:0]  paddr,
  input  logic [lmss_pkg::PDATA_W-1:0]  pwdata,
  output logic [lmss_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output lmss_pkg::cfg_t                cfg
);

  logic [1:0] index;
  logic       wr;

  assign index  = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level  <= lmss_pkg::LEVEL_RESET;
      cfg.dwell  <= lmss_pkg::DWELL_RESET;
      cfg.frames <= lmss_pkg::FRAMES_RESET;
      cfg.length <= lmss_pkg::LENGTH_RESET;
    end else if (wr) begin
      case (index)
        lmss_pkg::REG_LEVEL:  cfg.level  <= pwdata[0];
        lmss_pkg::REG_DWELL:  cfg.dwell  <= pwdata[15:0];
        lmss_pkg::REG_FRAMES: cfg.frames <= pwdata[12:0];
        lmss_pkg::REG_LENGTH: cfg.length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      lmss_pkg::REG_LEVEL:  prdata = {31'd0, cfg.level};
      lmss_pkg::REG_DWELL:  prdata = {16'd0, cfg.dwell};
      lmss_pkg::REG_FRAMES: prdata = {19'd0, cfg.frames};
      lmss_pkg::REG_LENGTH: prdata = {24'd0, cfg.length};
      default:              prdata = '0;
    endcase
  end

endmodule

### design/lmss_ctrl.sv
// scan and scroll sequencer: run state, store addressing and column drive
module lmss_ctrl #(
  parameter int COLUMNS     = lmss_pkg::COLUMNS_DEF,
  parameter int STORE_DEPTH = lmss_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lmss_pkg::cfg_t                 cfg,
  input  logic                           accept,
  input  logic [1:0]                     opcode,
  input  logic [7:0]                     byte_index,
  input  logic                           display_enable,
  output logic                           we,
  output logic [$clog2(STORE_DEPTH)-1:0] waddr,
  output logic [$clog2(STORE_DEPTH)-1:0] raddr,
  output logic                           fwd,
  output lmss_pkg::result_t              res
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [7:0] COL_MASK = (COLUMNS >= 8) ? 8'hFF : 8'((1 << COLUMNS) - 1);

  logic [1:0]    mode, mode_next;
  logic [CW-1:0] col, col_next;
  logic [15:0]   dcnt, dcnt_next;
  logic [12:0]   fcnt, fcnt_next;
  logic [7:0]    shifts, shifts_next;
  logic [7:0]    offset, offset_next;
  logic [AW-1:0] offmod, offmod_next;

  logic [CW-1:0] col_show;
  logic          active;
  logic          done_flag;
  logic [15:0]   dwell_eff;
  logic [16:0]   dcnt_inc;
  logic [AW:0]   addr_sum;
  logic [11:0]   idx_rem;
  logic [7:0]    col_bit;

  always_comb begin
    idx_rem = {4'd0, byte_index};
    for (int k = 3; k >= 0; k--) begin
      if (idx_rem >= 12'(STORE_DEPTH << k)) begin
        idx_rem = idx_rem - 12'(STORE_DEPTH << k);
      end
    end
  end

  assign we    = accept && (opcode == lmss_pkg::OP_LOAD);
  assign waddr = idx_rem[AW-1:0];

  assign dwell_eff = (cfg.dwell == 16'd0) ? 16'd1 : cfg.dwell;
  assign dcnt_inc  = {1'b0, dcnt} + 17'd1;

  always_comb begin
    mode_next   = mode;
    col_next    = col;
    dcnt_next   = dcnt;
    fcnt_next   = fcnt;
    shifts_next = shifts;
    offset_next = offset;
    offmod_next = offmod;
    col_show    = col;
    active      = (mode != lmss_pkg::MODE_IDLE);
    done_flag   = 1'b0;
    case (opcode)
      lmss_pkg::OP_LOAD: begin
      end
      lmss_pkg::OP_STATIC, lmss_pkg::OP_SCROLL: begin
        col_next  = '0;
        dcnt_next = '0;
        col_show  = '0;
        active    = 1'b1;
        if (opcode == lmss_pkg::OP_STATIC) begin
          mode_next = lmss_pkg::MODE_STATIC;
        end else begin
          mode_next   = lmss_pkg::MODE_SCROLL;
          offset_next = '0;
          offmod_next = '0;
          shifts_next = (cfg.length > lmss_pkg::SCROLL_MARGIN) ?
                        cfg.length - lmss_pkg::SCROLL_MARGIN : 8'd0;
          fcnt_next   = cfg.frames;
        end
      end
      default: begin
        if (mode != lmss_pkg::MODE_IDLE) begin
          if (mode == lmss_pkg::MODE_SCROLL && col == '0 && dcnt == 16'd0) begin
            if (shifts == 8'd0) begin
              active = 1'b0;
            end else if (fcnt == 13'd0 || !display_enable) begin
              shifts_next = shifts - 8'd1;
              offset_next = offset + 8'd1;
              if (offset == 8'hFF || offmod == AW'(STORE_DEPTH - 1)) begin
                offmod_next = '0;
              end else begin
                offmod_next = offmod + AW'(1);
              end
              fcnt_next = cfg.frames;
              if (shifts_next == 8'd0 || cfg.frames == 13'd0 || !display_enable) begin
                active = 1'b0;
              end
            end
            if (active) begin
              fcnt_next = fcnt_next - 13'd1;
            end
          end
          if (!active) begin
            mode_next = lmss_pkg::MODE_IDLE;
            done_flag = 1'b1;
          end else if (dcnt_inc >= {1'b0, dwell_eff}) begin
            dcnt_next = '0;
            if (col == CW'(COLUMNS - 1)) begin
              col_next = '0;
              if (mode == lmss_pkg::MODE_STATIC) begin
                mode_next = lmss_pkg::MODE_IDLE;
                done_flag = 1'b1;
              end
            end else begin
              col_next = col + CW'(1);
            end
          end else begin
            dcnt_next = dcnt_inc[15:0];
          end
        end
      end
    endcase
  end

  always_comb begin
    addr_sum = {1'b0, offmod_next} + (AW + 1)'(col_show);
    if (addr_sum >= (AW + 1)'(STORE_DEPTH)) begin
      addr_sum = addr_sum - (AW + 1)'(STORE_DEPTH);
    end
  end

  assign raddr = addr_sum[AW-1:0];
  assign fwd   = we && (waddr == raddr);

  assign col_bit = (int'(col_show) < 8) ? (8'd1 << col_show) : 8'd0;

  always_comb begin
    if (active) begin
      res.column_drive = (cfg.level ? col_bit : ~col_bit) & COL_MASK;
    end else begin
      res.column_drive = cfg.level ? 8'd0 : COL_MASK;
    end
    res.row_en = active;
    res.busy   = (mode_next != lmss_pkg::MODE_IDLE);
    res.done   = done_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= lmss_pkg::MODE_IDLE;
      col    <= '0;
      dcnt   <= '0;
      fcnt   <= '0;
      shifts <= '0;
      offset <= '0;
      offmod <= '0;
    end else if (accept && opcode != lmss_pkg::OP_LOAD) begin
      mode   <= mode_next;
      col    <= col_next;
      dcnt   <= dcnt_next;
      fcnt   <= fcnt_next;
      shifts <= shifts_next;
      offset <= offset_next;
      offmod <= offmod_next;
    end
  end

endmodule

### design/led_matrix_scroll_scanner_core.sv
// top level of the led matrix scroll scanner: registers, sequencer, store and output pipeline
// Takes one beat per clock while in_stall is low, load or tick alike, and answers every
// beat with exactly one result beat: on acceptance the sequencer updates the run state
// and issues the single read of the message store, then the store data is masked into
// the output register. Without stalls, a sustained rate of one beat per cycle is set by
// that one store read per beat; a load that hits the address shown on the same beat is
// forwarded around the store. The read stage register lets a new beat in while a result
// waits on a stalled output. The store has no reset and no clearing pass: entries read
// before they are loaded show undefined row data.
module led_matrix_scroll_scanner_core #(
  parameter int ROWS        = lmss_pkg::ROWS_DEF,
  parameter int COLUMNS     = lmss_pkg::COLUMNS_DEF,
  parameter int STORE_DEPTH = lmss_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    byte_index,
  input  logic [7:0]                    byte_value,
  input  logic                          display_enable,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    column_drive,
  output logic [7:0]                    row_drive,
  output logic                          busy_res,
  output logic                          run_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmss_pkg::PADDR_W-1:0]  paddr,
  input  logic [lmss_pkg::PDATA_W-1:0]  pwdata,
  output logic [lmss_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [7:0] ROW_MASK = (ROWS >= 8) ? 8'hFF : 8'((1 << ROWS) - 1);

  lmss_pkg::cfg_t    cfg;
  lmss_pkg::result_t ctrl_res;
  lmss_pkg::result_t s1_res;

  logic          accept;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          fwd;
  logic [7:0]    rdata;
  logic          s1_valid;
  logic          s1_fwd;
  logic [7:0]    s1_fwd_data;
  logic          s2_free;
  logic [7:0]    s1_row;

  assign s2_free  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s2_free;
  assign accept   = in_valid && !in_stall;

  lmss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmss_ctrl #(
    .COLUMNS     (COLUMNS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .opcode         (opcode),
    .byte_index     (byte_index),
    .display_enable (display_enable),
    .we             (we),
    .waddr          (waddr),
    .raddr          (raddr),
    .fwd            (fwd),
    .res            (ctrl_res)
  );

  lmss_ram #(
    .WIDTH (lmss_pkg::DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (byte_value),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res      <= ctrl_res;
      s1_fwd      <= fwd;
      s1_fwd_data <= byte_value;
    end
  end

  assign s1_row = s1_res.row_en ? ((s1_fwd ? s1_fwd_data : rdata) & ROW_MASK) : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      column_drive <= s1_res.column_drive;
      row_drive    <= s1_row;
      busy_res     <= s1_res.busy;
      run_done     <= s1_res.done;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_done) |-> !busy_res)
    else $error("run finished while still busy");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res && !run_done) |-> (row_drive == 8'd0))
    else $error("rows driven while idle");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_free) |=> (s1_valid && $stable(s1_res)))
    else $error("read stage lost its beat under stall");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(row_drive)))
    else $error("output beat changed under stall");

endmodule

### sim/tb_top.sv
// self-checking testbench for the led matrix scroll scanner core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic [7:0] val;
    logic       en;
  } scan_beat_t;

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic       busy;
    logic       done;
  } pin_state_t;

  localparam int N_PHASES       = 9;
  localparam int RUNS_PER_PHASE = 105;
  localparam int QUIET_LIMIT    = 20000;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    opcode;
  logic [7:0]                    byte_index;
  logic [7:0]                    byte_value;
  logic                          display_enable;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    column_drive;
  logic [7:0]                    row_drive;
  logic                          busy_res;
  logic                          run_done;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lmss_pkg::PADDR_W-1:0]  paddr;
  logic [lmss_pkg::PDATA_W-1:0]  pwdata;
  logic [lmss_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  scan_beat_t beat_backlog[$];
  pin_state_t pin_forecast[$];

  int  send_idle_pct;
  int  stall_pct;
  int  errors;
  int  quiet;
  int  queued;
  logic took;

  // predictor state and register shadow
  logic [7:0]  pattern_mem [0:255];
  logic [1:0]  run_state;
  int unsigned scan_col;
  int unsigned dwell_spent;
  int unsigned frames_left;
  int unsigned positions_left;
  int unsigned window_base;
  logic        act_level;
  logic [15:0] dwell_cfg;
  logic [12:0] frames_cfg;
  logic [7:0]  length_cfg;

  led_matrix_scroll_scanner_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .byte_index(byte_index), .byte_value(byte_value),
    .display_enable(display_enable),
    .out_valid(out_valid), .out_stall(out_stall),
    .column_drive(column_drive), .row_drive(row_drive),
    .busy_res(busy_res), .run_done(run_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] frame_pins(input logic lit);
    logic [7:0] sel;
    if (!lit) begin
      return {act_level ? 8'h00 : 8'hFF, 8'h00};
    end
    sel = 8'h01 << scan_col;
    return {act_level ? sel : ~sel, pattern_mem[(window_base + scan_col) % 256]};
  endfunction

  function automatic pin_state_t scan_step(input scan_beat_t b);
    pin_state_t  r;
    logic        show;
    int unsigned dw;
    logic [15:0] pins;
    r.done = 1'b0;
    if (b.op == lmss_pkg::OP_LOAD) begin
      pattern_mem[b.idx] = b.val;
      pins = frame_pins(run_state != lmss_pkg::MODE_IDLE);
    end else if (b.op == lmss_pkg::OP_STATIC || b.op == lmss_pkg::OP_SCROLL) begin
      scan_col = 0;
      dwell_spent = 0;
      if (b.op == lmss_pkg::OP_STATIC) begin
        run_state = lmss_pkg::MODE_STATIC;
      end else begin
        run_state = lmss_pkg::MODE_SCROLL;
        window_base = 0;
        positions_left = (length_cfg > lmss_pkg::SCROLL_MARGIN) ?
                         length_cfg - lmss_pkg::SCROLL_MARGIN : 0;
        frames_left = frames_cfg;
      end
      pins = frame_pins(1'b1);
    end else if (run_state == lmss_pkg::MODE_IDLE) begin
      pins = frame_pins(1'b0);
    end else begin
      show = 1'b1;
      dw = (dwell_cfg == 0) ? 1 : dwell_cfg;
      // frame boundary of a scroll run
      if (run_state == lmss_pkg::MODE_SCROLL && scan_col == 0 && dwell_spent == 0) begin
        if (positions_left == 0) begin
          show = 1'b0;
        end else if (frames_left == 0 || !b.en) begin
          positions_left = (positions_left - 1) & 'hFF;
          window_base = (window_base + 1) & 'hFF;
          frames_left = frames_cfg;
          if (positions_left == 0 || frames_left == 0 || !b.en) show = 1'b0;
        end
        if (show) frames_left = (frames_left - 1) & 'h1FFF;
      end
      if (!show) begin
        run_state = lmss_pkg::MODE_IDLE;
        r.done = 1'b1;
        pins = frame_pins(1'b0);
      end else begin
        pins = frame_pins(1'b1);
        dwell_spent++;
        if (dwell_spent >= dw) begin
          dwell_spent = 0;
          scan_col++;
          if (scan_col >= 8) begin
            scan_col = 0;
            if (run_state == lmss_pkg::MODE_STATIC) begin
              run_state = lmss_pkg::MODE_IDLE;
              r.done = 1'b1;
            end
          end
        end
      end
    end
    {r.cols, r.rows} = pins;
    r.busy = (run_state != lmss_pkg::MODE_IDLE);
    return r;
  endfunction

  // monitor: input acceptance, result check, watchdog
  always @(posedge clk) begin
    pin_state_t got;
    pin_state_t want;
    if (rst) begin
      took = 1'b0;
      quiet = 0;
    end else begin
      took = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got = {column_drive, row_drive, busy_res, run_done};
        if (pin_forecast.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: cols %h rows %h busy %b done %b",
                     got.cols, got.rows, got.busy, got.done);
        end else begin
          want = pin_forecast.pop_front();
          if (got.cols !== want.cols || got.rows !== want.rows ||
              got.busy !== want.busy || got.done !== want.done) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp cols %h rows %h busy %b done %b, ",
                        "got cols %h rows %h busy %b done %b"},
                       want.cols, want.rows, want.busy, want.done,
                       got.cols, got.rows, got.busy, got.done);
          end
        end
      end
      if (took) pin_forecast.push_back(scan_step({opcode, byte_index, byte_value, display_enable}));
      quiet = (took || (out_valid && !out_stall)) ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // driver: present pending beats, random sender gaps and receiver stalls
  always @(negedge clk) begin
    scan_beat_t b;
    if (!rst) begin
      if (!in_valid || took) begin
        if (beat_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          b = beat_backlog.pop_front();
          in_valid       <= 1'b1;
          opcode         <= b.op;
          byte_index     <= b.idx;
          byte_value     <= b.val;
          display_enable <= b.en;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_beat(input int unsigned op, input int unsigned idx,
                           input int unsigned val, input int unsigned en);
    scan_beat_t b;
    b.op  = op[1:0];
    b.idx = idx[7:0];
    b.val = val[7:0];
    b.en  = en[0];
    beat_backlog.push_back(b);
    queued++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lmss_pkg::REG_LEVEL:  act_level  = val[0];
      lmss_pkg::REG_DWELL:  dwell_cfg  = val[15:0];
      lmss_pkg::REG_FRAMES: frames_cfg = val[12:0];
      default:              length_cfg = val[7:0];
    endcase
  endtask

  task automatic program_regs(input logic lvl, input logic [15:0] dw,
                              input logic [12:0] fr, input logic [7:0] len);
    cfg_write(lmss_pkg::REG_LEVEL, {31'd0, lvl});
    cfg_write(lmss_pkg::REG_DWELL, {16'd0, dw});
    cfg_write(lmss_pkg::REG_FRAMES, {19'd0, fr});
    cfg_write(lmss_pkg::REG_LENGTH, {24'd0, len});
  endtask

  // mostly well-formed runs with random content, some raw noise
  task automatic random_runs(input int quota);
    int start_count;
    int n;
    int k;
    int dw;
    logic is_static;
    start_count = queued;
    while (queued - start_count < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++)
          push_beat(lmss_pkg::OP_LOAD, $urandom, $urandom, $urandom);
        is_static = 1'($urandom_range(0, 1));
        push_beat(is_static ? lmss_pkg::OP_STATIC : lmss_pkg::OP_SCROLL,
                  $urandom, $urandom, $urandom);
        dw = (dwell_cfg == 0) ? 1 : dwell_cfg;
        if (is_static) n = $urandom_range(1, (8 * dw + 2 > 40) ? 40 : 8 * dw + 2);
        else n = $urandom_range(1, 48);
        for (k = 0; k < n; k++)
          push_beat(lmss_pkg::OP_TICK, $urandom, $urandom, $urandom_range(0, 15) != 0);
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          push_beat($urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int p;
    int k;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    opcode = lmss_pkg::OP_TICK;
    byte_index = 8'd0;
    byte_value = 8'd0;
    display_enable = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    quiet = 0;
    queued = 0;
    took = 1'b0;
    run_state = lmss_pkg::MODE_IDLE;
    scan_col = 0;
    dwell_spent = 0;
    frames_left = 0;
    positions_left = 0;
    window_base = 0;
    act_level = lmss_pkg::LEVEL_RESET;
    dwell_cfg = lmss_pkg::DWELL_RESET;
    frames_cfg = lmss_pkg::FRAMES_RESET;
    length_cfg = lmss_pkg::LENGTH_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      case (p)
        0: program_regs(1'b1, 16'd1, 13'd1, 8'd9);
        1: program_regs(1'b0, 16'd2, 13'd2, 8'd12);
        2: program_regs(1'b1, 16'd0, 13'd3, 8'd10);
        3: program_regs(1'b0, 16'd1, 13'd0, 8'd20);
        4: program_regs(1'b1, 16'd3, 13'd1, 8'd255);
        5: program_regs(1'b0, 16'd1, 13'd2, 8'd0);
        6: program_regs(1'b1, 16'd2, 13'd1, 8'd7);
        7: program_regs(1'b0, 16'd65535, 13'd8191, 8'd8);
        default: program_regs(1'b1, 16'd1, 13'd1, 8'd8);
      endcase
      if (p == 0) begin
        // load every store entry before anything is shown
        for (k = 0; k < 256; k++)
          push_beat(lmss_pkg::OP_LOAD, k, $urandom_range(0, 255), 1);
        push_beat(lmss_pkg::OP_TICK, 0, 0, 1);
        push_beat(lmss_pkg::OP_LOAD, 0, 8'h00, 0);
        push_beat(lmss_pkg::OP_LOAD, 255, 8'hFF, 1);
        push_beat(lmss_pkg::OP_STATIC, 0, 0, 1);
        for (k = 0; k < 8; k++)
          push_beat(lmss_pkg::OP_TICK, k, 0, k % 2);
        // enable low at the first boundary ends the scroll
        push_beat(lmss_pkg::OP_SCROLL, 0, 0, 1);
        push_beat(lmss_pkg::OP_TICK, 0, 0, 0);
        // static run keeps the advanced offset
        push_beat(lmss_pkg::OP_STATIC, 0, 0, 1);
        for (k = 0; k < 3; k++)
          push_beat(lmss_pkg::OP_TICK, 0, 0, 1);
        push_beat(lmss_pkg::OP_SCROLL, 0, 0, 1);
        push_beat(lmss_pkg::OP_LOAD, 0, 8'hA5, 1);
        for (k = 0; k < 3; k++)
          push_beat(lmss_pkg::OP_TICK, 0, 0, 1);
      end
      random_runs(RUNS_PER_PHASE);
      // bring the run state back to idle before the next register writes
      push_beat(lmss_pkg::OP_SCROLL, 0, 0, 1);
      push_beat(lmss_pkg::OP_TICK, 0, 0, 0);
      @(posedge clk);
      while (beat_backlog.size() != 0 || pin_forecast.size() != 0 || in_valid)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pin_forecast.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### files.f
design/lmss_pkg.sv
design/lmss_ram.sv
design/lmss_regs.sv
design/lmss_ctrl.sv
design/led_matrix_scroll_scanner_core.sv
sim/tb_top.sv
